>>> hdl/bsa_pkg.sv
// Package for the banker's safety allocator: shared widths, codes,
// the controller state type and the controller/datapath command and status structs.
// No dependencies.
package bsa_pkg;

  localparam int PROCESSES_DEF  = 8;
  localparam int RESOURCES_DEF  = 4;
  localparam int COUNT_BITS_DEF = 16;

  localparam int AMT_W    = 16;
  localparam int PROC_W   = 3;
  localparam int STATUS_W = 3;
  localparam int FIN_W    = 4;
  localparam int PC_W     = 4;
  localparam int RC_W     = 3;
  localparam int MAX_RES  = 4;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [PC_W-1:0] PC_RESET = 4'd8;
  localparam logic [RC_W-1:0] RC_RESET = 3'd3;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_SET   = 2'd1,
    KIND_REQ   = 2'd2,
    KIND_CHECK = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_NEED   = 3'd1,
    ST_AVAIL  = 3'd2,
    ST_UNSAFE = 3'd3,
    ST_BAD    = 3'd4
  } status_t;

  typedef enum logic {
    REG_PROCESS_COUNT  = 1'b0,
    REG_RESOURCE_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_REQ_CHK,
    S_WALK_INIT,
    S_WALK_RD,
    S_WALK_EV,
    S_WALK_END
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    load_row;
    logic    set_free;
    logic    rd_req;
    logic    grant;
    logic    walk_init;
    logic    rd_walk;
    logic    walk_step;
    logic    rollback;
    logic    emit;
    logic    use_cnt;
    status_t code;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  proc_bad;
    logic  row_bad;
    logic  need_exc;
    logic  free_exc;
    logic  last;
    logic  found;
    logic  all_done;
  } sts_t;

endpackage

>>> hdl/bankers_safety_allocator.sv
// Banker's algorithm allocator. Load_row, set_available and an out-of-range request answer
// from the decode state; a request that fails its need or free test answers from the request
// check; check and a request that passes both run a safety walk (a row read and a fit test
// per process in each pass, passes <= np+1, until a pass takes no process).
// One transaction at a time; a start is taken in the result's strobe cycle. No receiver stall.
// Synchronous active-low reset clears control state, free counts and row valid bits.
module bankers_safety_allocator #(
  parameter int PROCESSES  = bsa_pkg::PROCESSES_DEF,
  parameter int RESOURCES  = bsa_pkg::RESOURCES_DEF,
  parameter int COUNT_BITS = bsa_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input transaction: taken when start is high and busy is low.
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_kind,
  input  logic [bsa_pkg::PROC_W-1:0]    in_process,
  input  logic [bsa_pkg::AMT_W-1:0]     in_amount_a,
  input  logic [bsa_pkg::AMT_W-1:0]     in_amount_b,
  input  logic [bsa_pkg::AMT_W-1:0]     in_amount_c,
  input  logic [bsa_pkg::AMT_W-1:0]     in_amount_d,
  input  logic [bsa_pkg::AMT_W-1:0]     in_held_a,
  input  logic [bsa_pkg::AMT_W-1:0]     in_held_b,
  input  logic [bsa_pkg::AMT_W-1:0]     in_held_c,
  input  logic [bsa_pkg::AMT_W-1:0]     in_held_d,
  // Result transaction: valid for exactly one cycle.
  output logic                          out_strobe,
  output logic [bsa_pkg::STATUS_W-1:0]  out_status,
  output logic [bsa_pkg::FIN_W-1:0]     out_finished_count,
  // APB configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bsa_pkg::PADDR_W-1:0]   paddr,
  input  logic [bsa_pkg::PDATA_W-1:0]   pwdata,
  output logic [bsa_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int NPW = $clog2(PROCESSES + 1);

  logic [bsa_pkg::PC_W-1:0] pc_r;
  logic [bsa_pkg::RC_W-1:0] rc_r;
  logic [NPW-1:0]           np;
  logic [bsa_pkg::RC_W-1:0] nr;
  logic                     wr_acc;
  bsa_pkg::reg_idx_t        reg_sel;

  bsa_pkg::cmd_t cmd;
  bsa_pkg::sts_t sts;

  logic [bsa_pkg::MAX_RES-1:0][bsa_pkg::AMT_W-1:0] amt;
  logic [bsa_pkg::MAX_RES-1:0][bsa_pkg::AMT_W-1:0] hold;

  // Registers sit at byte addresses 0 and 4; bit 2 selects between them.
  assign reg_sel = bsa_pkg::reg_idx_t'(paddr[2]);
  assign wr_acc  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= bsa_pkg::PC_RESET;
      rc_r <= bsa_pkg::RC_RESET;
    end else if (wr_acc) begin
      case (reg_sel)
        bsa_pkg::REG_PROCESS_COUNT:  pc_r <= pwdata[bsa_pkg::PC_W-1:0];
        bsa_pkg::REG_RESOURCE_COUNT: rc_r <= pwdata[bsa_pkg::RC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      bsa_pkg::REG_PROCESS_COUNT:  prdata = bsa_pkg::PDATA_W'(pc_r);
      bsa_pkg::REG_RESOURCE_COUNT: prdata = bsa_pkg::PDATA_W'(rc_r);
      default:                     prdata = '0;
    endcase
  end

  // Effective counts: zero acts as one, and values past the build size are clamped.
  always_comb begin
    if (pc_r == '0) begin
      np = NPW'(1);
    end else if (int'(pc_r) > PROCESSES) begin
      np = NPW'(PROCESSES);
    end else begin
      np = NPW'(pc_r);
    end
    if (rc_r == '0) begin
      nr = bsa_pkg::RC_W'(1);
    end else if (int'(rc_r) > RESOURCES) begin
      nr = bsa_pkg::RC_W'(RESOURCES);
    end else begin
      nr = rc_r;
    end
  end

  assign amt  = {in_amount_d, in_amount_c, in_amount_b, in_amount_a};
  assign hold = {in_held_d, in_held_c, in_held_b, in_held_a};

  bsa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  bsa_datapath #(
    .PROCESSES  (PROCESSES),
    .RESOURCES  (RESOURCES),
    .COUNT_BITS (COUNT_BITS),
    .NPW        (NPW)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .np                 (np),
    .nr                 (nr),
    .in_kind            (in_kind),
    .in_process         (in_process),
    .in_amt             (amt),
    .in_hold            (hold),
    .out_strobe         (out_strobe),
    .out_status         (out_status),
    .out_finished_count (out_finished_count)
  );

endmodule

>>> hdl/bsa_ctrl.sv
// Controller state machine of the banker's safety allocator.
// Depends on bsa_pkg; drives commands to bsa_datapath and reads its status.
module bsa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  bsa_pkg::sts_t sts,
  output bsa_pkg::cmd_t cmd,
  output logic          busy
);

  bsa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bsa_pkg::S_IDLE: begin
        if (start) state_nxt = bsa_pkg::S_DECODE;
      end
      bsa_pkg::S_DECODE: begin
        case (sts.kind)
          bsa_pkg::KIND_REQ:   state_nxt = sts.proc_bad ? bsa_pkg::S_IDLE : bsa_pkg::S_REQ_CHK;
          bsa_pkg::KIND_CHECK: state_nxt = bsa_pkg::S_WALK_INIT;
          default:             state_nxt = bsa_pkg::S_IDLE;
        endcase
      end
      bsa_pkg::S_REQ_CHK: begin
        state_nxt = (sts.need_exc || sts.free_exc) ? bsa_pkg::S_IDLE : bsa_pkg::S_WALK_INIT;
      end
      bsa_pkg::S_WALK_INIT: state_nxt = bsa_pkg::S_WALK_RD;
      bsa_pkg::S_WALK_RD:   state_nxt = bsa_pkg::S_WALK_EV;
      bsa_pkg::S_WALK_EV: begin
        state_nxt = (sts.last && !sts.found) ? bsa_pkg::S_WALK_END : bsa_pkg::S_WALK_RD;
      end
      bsa_pkg::S_WALK_END: state_nxt = bsa_pkg::S_IDLE;
      default:             state_nxt = bsa_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    cmd.code = bsa_pkg::ST_OK;
    busy     = (state_r != bsa_pkg::S_IDLE);
    case (state_r)
      bsa_pkg::S_IDLE: begin
        cmd.capture = start;
      end
      bsa_pkg::S_DECODE: begin
        case (sts.kind)
          bsa_pkg::KIND_LOAD: begin
            cmd.emit = 1'b1;
            if (sts.proc_bad || sts.row_bad) begin
              cmd.code = bsa_pkg::ST_BAD;
            end else begin
              cmd.load_row = 1'b1;
            end
          end
          bsa_pkg::KIND_SET: begin
            cmd.set_free = 1'b1;
            cmd.emit     = 1'b1;
          end
          bsa_pkg::KIND_REQ: begin
            if (sts.proc_bad) begin
              cmd.emit = 1'b1;
              cmd.code = bsa_pkg::ST_BAD;
            end else begin
              cmd.rd_req = 1'b1;
            end
          end
          default: ;
        endcase
      end
      bsa_pkg::S_REQ_CHK: begin
        if (sts.need_exc) begin
          cmd.emit = 1'b1;
          cmd.code = bsa_pkg::ST_NEED;
        end else if (sts.free_exc) begin
          cmd.emit = 1'b1;
          cmd.code = bsa_pkg::ST_AVAIL;
        end else begin
          cmd.grant = 1'b1;
        end
      end
      bsa_pkg::S_WALK_INIT: cmd.walk_init = 1'b1;
      bsa_pkg::S_WALK_RD:   cmd.rd_walk = 1'b1;
      bsa_pkg::S_WALK_EV:   cmd.walk_step = 1'b1;
      bsa_pkg::S_WALK_END: begin
        cmd.emit    = 1'b1;
        cmd.use_cnt = 1'b1;
        if (!sts.all_done) begin
          cmd.code     = bsa_pkg::ST_UNSAFE;
          cmd.rollback = (sts.kind == bsa_pkg::KIND_REQ);
        end
      end
      default: ;
    endcase
  end

endmodule

>>> hdl/bsa_datapath.sv
// Datapath of the banker's safety allocator: row memories, free counts,
// work vector and safety-walk registers. Depends on bsa_pkg; driven by bsa_ctrl.
module bsa_datapath #(
  parameter int PROCESSES  = bsa_pkg::PROCESSES_DEF,
  parameter int RESOURCES  = bsa_pkg::RESOURCES_DEF,
  parameter int COUNT_BITS = bsa_pkg::COUNT_BITS_DEF,
  parameter int NPW        = $clog2(PROCESSES + 1)
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  bsa_pkg::cmd_t                                  cmd,
  output bsa_pkg::sts_t                                  sts,
  input  logic [NPW-1:0]                                 np,
  input  logic [bsa_pkg::RC_W-1:0]                       nr,
  input  logic [1:0]                                     in_kind,
  input  logic [bsa_pkg::PROC_W-1:0]                     in_process,
  input  logic [bsa_pkg::MAX_RES-1:0][bsa_pkg::AMT_W-1:0] in_amt,
  input  logic [bsa_pkg::MAX_RES-1:0][bsa_pkg::AMT_W-1:0] in_hold,
  output logic                                           out_strobe,
  output logic [bsa_pkg::STATUS_W-1:0]                   out_status,
  output logic [bsa_pkg::FIN_W-1:0]                      out_finished_count
);

  localparam int PW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int WB = COUNT_BITS + $clog2(PROCESSES + 1);
  localparam int XW = (COUNT_BITS > bsa_pkg::AMT_W) ? COUNT_BITS : bsa_pkg::AMT_W;
  localparam logic [XW-1:0] MASK_X = XW'({COUNT_BITS{1'b1}});

  typedef logic [RESOURCES-1:0][COUNT_BITS-1:0] row_t;

  // Captured item.
  bsa_pkg::kind_t                                 kind_r;
  logic [bsa_pkg::PROC_W-1:0]                     proc_r;
  logic [bsa_pkg::MAX_RES-1:0][bsa_pkg::AMT_W-1:0] amt_r;
  logic [bsa_pkg::MAX_RES-1:0][bsa_pkg::AMT_W-1:0] hold_r;

  // Row memories with per-row valid bits.
  row_t                 held_mem [PROCESSES];
  row_t                 need_mem [PROCESSES];
  logic [PROCESSES-1:0] row_vld_r;
  row_t                 held_q_r, need_q_r;
  logic                 rd_vld_r;

  row_t free_r, save_free_r, save_held_r, save_need_r;

  logic [RESOURCES-1:0][WB-1:0] work_r;
  logic [PROCESSES-1:0]         done_r;
  logic [PW-1:0]                ptr_r;
  logic [NPW-1:0]               cnt_r;
  logic                         found_r;

  logic                         out_strobe_r;
  logic [bsa_pkg::STATUS_W-1:0] out_status_r;
  logic [bsa_pkg::FIN_W-1:0]    out_fin_r;

  logic [PW-1:0] proc_addr;
  logic [PW-1:0] rd_addr;
  row_t          held_rd, need_rd;
  logic          wr_en;
  row_t          wr_held, wr_need;
  logic          row_bad, need_exc, free_exc, fits, take, last;
  logic [NPW:0]  ptr_inc;

  assign proc_addr = PW'(proc_r);
  assign rd_addr   = cmd.rd_walk ? ptr_r : proc_addr;
  assign held_rd   = rd_vld_r ? held_q_r : '0;
  assign need_rd   = rd_vld_r ? need_q_r : '0;

  always_comb begin
    row_bad  = 1'b0;
    need_exc = 1'b0;
    free_exc = 1'b0;
    fits     = 1'b1;
    for (int r = 0; r < RESOURCES; r++) begin
      if (3'(r) < nr) begin
        if (XW'(amt_r[r]) > MASK_X || hold_r[r] > amt_r[r]) row_bad = 1'b1;
        if (XW'(amt_r[r]) > XW'(need_rd[r])) need_exc = 1'b1;
        if (XW'(amt_r[r]) > XW'(free_r[r])) free_exc = 1'b1;
        if (WB'(need_rd[r]) > work_r[r]) fits = 1'b0;
      end
    end
  end

  assign take    = !done_r[ptr_r] && fits;
  assign ptr_inc = (NPW + 1)'(ptr_r) + 1'b1;
  assign last    = (ptr_inc == (NPW + 1)'(np));

  always_comb begin
    sts          = '0;
    sts.kind     = kind_r;
    sts.proc_bad = ((NPW + 1)'(proc_r) >= (NPW + 1)'(np));
    sts.row_bad  = row_bad;
    sts.need_exc = need_exc;
    sts.free_exc = free_exc;
    sts.last     = last;
    sts.found    = found_r || take;
    sts.all_done = (cnt_r == np);
  end

  // Row write data: a new row, a granted row or the saved row.
  always_comb begin
    wr_en   = cmd.load_row || cmd.grant || cmd.rollback;
    wr_held = save_held_r;
    wr_need = save_need_r;
    if (cmd.load_row) begin
      for (int r = 0; r < RESOURCES; r++) begin
        if (3'(r) < nr) begin
          wr_held[r] = COUNT_BITS'(hold_r[r]);
          wr_need[r] = COUNT_BITS'(amt_r[r] - hold_r[r]);
        end else begin
          wr_held[r] = '0;
          wr_need[r] = '0;
        end
      end
    end else if (cmd.grant) begin
      for (int r = 0; r < RESOURCES; r++) begin
        if (3'(r) < nr) begin
          wr_held[r] = held_rd[r] + COUNT_BITS'(amt_r[r]);
          wr_need[r] = need_rd[r] - COUNT_BITS'(amt_r[r]);
        end else begin
          wr_held[r] = held_rd[r];
          wr_need[r] = need_rd[r];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      held_mem[proc_addr] <= wr_held;
      need_mem[proc_addr] <= wr_need;
    end
    if (cmd.rd_walk || cmd.rd_req) begin
      held_q_r <= held_mem[rd_addr];
      need_q_r <= need_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (wr_en) row_vld_r[proc_addr] <= 1'b1;
      if (cmd.rd_walk || cmd.rd_req) rd_vld_r <= row_vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= bsa_pkg::kind_t'(in_kind);
      proc_r <= in_process;
      amt_r  <= in_amt;
      hold_r <= in_hold;
    end
    if (cmd.grant) begin
      save_held_r <= held_rd;
      save_need_r <= need_rd;
      save_free_r <= free_r;
    end
    if (cmd.walk_init) begin
      for (int r = 0; r < RESOURCES; r++) begin
        work_r[r] <= WB'(free_r[r]);
      end
    end else if (cmd.walk_step && take) begin
      for (int r = 0; r < RESOURCES; r++) begin
        if (3'(r) < nr) work_r[r] <= work_r[r] + WB'(held_rd[r]);
      end
    end
  end

  // Free counts reset to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= '0;
    end else if (cmd.set_free) begin
      for (int r = 0; r < RESOURCES; r++) begin
        if (3'(r) >= nr) begin
          free_r[r] <= '0;
        end else if (XW'(amt_r[r]) > MASK_X) begin
          free_r[r] <= {COUNT_BITS{1'b1}};
        end else begin
          free_r[r] <= COUNT_BITS'(amt_r[r]);
        end
      end
    end else if (cmd.grant) begin
      for (int r = 0; r < RESOURCES; r++) begin
        if (3'(r) < nr) free_r[r] <= free_r[r] - COUNT_BITS'(amt_r[r]);
      end
    end else if (cmd.rollback) begin
      free_r <= save_free_r;
    end
  end

  // Safety-walk control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r  <= '0;
      ptr_r   <= '0;
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else if (cmd.walk_init) begin
      done_r  <= '0;
      ptr_r   <= '0;
      cnt_r   <= '0;
      found_r <= 1'b0;
    end else if (cmd.walk_step) begin
      if (take) begin
        done_r[ptr_r] <= 1'b1;
        cnt_r         <= cnt_r + 1'b1;
      end
      if (last) begin
        ptr_r   <= '0;
        found_r <= 1'b0;
      end else begin
        ptr_r   <= ptr_r + 1'b1;
        found_r <= found_r || take;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.code;
      out_fin_r    <= cmd.use_cnt ? bsa_pkg::FIN_W'(cnt_r) : '0;
    end
  end

  assign out_strobe         = out_strobe_r;
  assign out_status         = out_status_r;
  assign out_finished_count = out_fin_r;

endmodule

>>> test/bankers_safety_allocator_tb.sv
// Self-checking testbench for bankers_safety_allocator: directed rows, then random
// transactions over several process/resource settings, checked against a local predictor.
// Depends on bsa_pkg and the bankers_safety_allocator RTL.
module bankers_safety_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPROC = 8;
  localparam int NRES  = 4;
  localparam int ITEMS_PER_PHASE = 210;
  localparam int DRAIN_CYCLES = 200;

  // One input transaction, plus an optional typed expectation for directed rows.
  typedef struct {
    bsa_pkg::kind_t   kind;
    logic [2:0]       proc_idx;
    logic [15:0]      amt [NRES];
    logic [15:0]      hold [NRES];
    bit               typed;
    bsa_pkg::status_t exp_status;
    logic [3:0]       exp_fin;
  } alloc_txn_t;

  typedef struct {
    bsa_pkg::status_t status;
    logic [3:0]       fin;
  } alloc_answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] kind_drv = '0;
  logic [bsa_pkg::PROC_W-1:0] proc_drv = '0;
  logic [bsa_pkg::AMT_W-1:0] amt_drv [NRES] = '{default: '0};
  logic [bsa_pkg::AMT_W-1:0] held_drv [NRES] = '{default: '0};
  logic out_strobe;
  logic [bsa_pkg::STATUS_W-1:0] out_status;
  logic [bsa_pkg::FIN_W-1:0] out_finished_count;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [bsa_pkg::PADDR_W-1:0] paddr = '0;
  logic [bsa_pkg::PDATA_W-1:0] pwdata = '0;
  logic [bsa_pkg::PDATA_W-1:0] prdata;
  logic pready;

  // Predictor state: the allocator's tables and its two registers.
  logic [15:0] held_tab [NPROC][NRES];
  logic [15:0] need_tab [NPROC][NRES];
  logic [15:0] free_cnt [NRES];
  logic [3:0]  proc_cfg;
  logic [2:0]  res_cfg;

  alloc_answer_t pending_answers [$];
  alloc_txn_t    stim_rows [$];
  int unsigned   error_count = 0;

  bankers_safety_allocator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(kind_drv), .in_process(proc_drv),
    .in_amount_a(amt_drv[0]), .in_amount_b(amt_drv[1]),
    .in_amount_c(amt_drv[2]), .in_amount_d(amt_drv[3]),
    .in_held_a(held_drv[0]), .in_held_b(held_drv[1]),
    .in_held_c(held_drv[2]), .in_held_d(held_drv[3]),
    .out_strobe(out_strobe), .out_status(out_status),
    .out_finished_count(out_finished_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #30ms;
    $display("bankers_safety_allocator verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Effective counts: zero acts as one, anything past the table size clamps to it.
  function automatic int unsigned live_procs();
    if (proc_cfg == 0) return 1;
    if (proc_cfg > NPROC) return NPROC;
    return proc_cfg;
  endfunction

  function automatic int unsigned live_res();
    if (res_cfg == 0) return 1;
    if (res_cfg > NRES) return NRES;
    return res_cfg;
  endfunction

  // Safety walk: repeatedly finish the lowest unfinished process whose need fits
  // the work vector. Work is 20 bits so returned holdings never wrap it.
  function automatic int unsigned finishable_count();
    logic [19:0] work [NRES];
    bit finished [NPROC];
    int unsigned np, nr, cnt;
    bit progress, fits;
    np = live_procs();
    nr = live_res();
    cnt = 0;
    progress = 1'b1;
    for (int r = 0; r < NRES; r++) work[r] = 20'(free_cnt[r]);
    for (int p = 0; p < NPROC; p++) finished[p] = 1'b0;
    while (progress) begin
      progress = 1'b0;
      for (int p = 0; p < np && !progress; p++) begin
        if (!finished[p]) begin
          fits = 1'b1;
          for (int r = 0; r < nr; r++) if (20'(need_tab[p][r]) > work[r]) fits = 1'b0;
          if (fits) begin
            for (int r = 0; r < nr; r++) work[r] = work[r] + 20'(held_tab[p][r]);
            finished[p] = 1'b1;
            cnt++;
            progress = 1'b1;
          end
        end
      end
    end
    return cnt;
  endfunction

  // Applies one accepted transaction to the predictor state and returns its answer.
  function automatic alloc_answer_t allocate_step(input alloc_txn_t t);
    alloc_answer_t ans;
    int unsigned np, nr, p;
    bit bad;
    logic [15:0] keep_held [NRES], keep_need [NRES], keep_free [NRES];
    np = live_procs();
    nr = live_res();
    p = t.proc_idx;
    ans.status = bsa_pkg::ST_OK;
    ans.fin = '0;
    case (t.kind)
      bsa_pkg::KIND_LOAD: begin
        bad = (p >= np);
        for (int r = 0; r < nr; r++) if (t.hold[r] > t.amt[r]) bad = 1'b1;
        if (bad) begin
          ans.status = bsa_pkg::ST_BAD;
        end else begin
          for (int r = 0; r < NRES; r++) begin
            held_tab[p][r] = (r < nr) ? t.hold[r] : 16'd0;
            need_tab[p][r] = (r < nr) ? t.amt[r] - t.hold[r] : 16'd0;
          end
        end
      end
      bsa_pkg::KIND_SET: begin
        for (int r = 0; r < NRES; r++) free_cnt[r] = (r < nr) ? t.amt[r] : 16'd0;
      end
      bsa_pkg::KIND_REQ: begin
        if (p >= np) begin
          ans.status = bsa_pkg::ST_BAD;
        end else begin
          // Need is tested over every live resource before availability is.
          for (int r = 0; r < nr; r++)
            if (t.amt[r] > need_tab[p][r]) ans.status = bsa_pkg::ST_NEED;
          if (ans.status == bsa_pkg::ST_OK)
            for (int r = 0; r < nr; r++)
              if (t.amt[r] > free_cnt[r]) ans.status = bsa_pkg::ST_AVAIL;
          if (ans.status == bsa_pkg::ST_OK) begin
            keep_held = held_tab[p];
            keep_need = need_tab[p];
            keep_free = free_cnt;
            for (int r = 0; r < nr; r++) begin
              free_cnt[r] -= t.amt[r];
              held_tab[p][r] += t.amt[r];
              need_tab[p][r] -= t.amt[r];
            end
            ans.fin = 4'(finishable_count());
            if (ans.fin != np) begin
              // Unsafe: the tentative grant is undone.
              ans.status = bsa_pkg::ST_UNSAFE;
              held_tab[p] = keep_held;
              need_tab[p] = keep_need;
              free_cnt = keep_free;
            end
          end
        end
      end
      default: begin
        ans.fin = 4'(finishable_count());
        ans.status = (ans.fin == np) ? bsa_pkg::ST_OK : bsa_pkg::ST_UNSAFE;
      end
    endcase
    return ans;
  endfunction

  // Result side: the receiver cannot stall, so every strobe is checked at once.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_answers.size() == 0) begin
        $display("%0t ns: result transaction with nothing expected", $realtime);
        error_count++;
      end else begin
        if (out_status != pending_answers[0].status)
          report_mismatch("status", out_status, pending_answers[0].status);
        if (out_finished_count != pending_answers[0].fin)
          report_mismatch("finished_count", out_finished_count, pending_answers[0].fin);
        void'(pending_answers.pop_front());
      end
    end
  end

  // Holds start and the fields until the block takes them. Inputs read right after
  // the edge still show their pre-edge values, so busy here is what the block saw.
  task automatic send_txn(input alloc_txn_t t, input bit allow_gap);
    alloc_answer_t ans;
    int unsigned gap;
    start <= 1'b1;
    kind_drv <= t.kind;
    proc_drv <= t.proc_idx;
    for (int r = 0; r < NRES; r++) begin
      amt_drv[r] <= t.amt[r];
      held_drv[r] <= t.hold[r];
    end
    do @(posedge clk); while (busy);
    ans = allocate_step(t);
    if (t.typed) begin
      ans.status = t.exp_status;
      ans.fin = t.exp_fin;
    end
    pending_answers.insert(pending_answers.size(), ans);
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // One APB transaction, setup then access; the caller ends the burst. A write is
  // followed by a read-back.
  task automatic apb_access(input bsa_pkg::reg_idx_t idx, input bit is_write,
                            input logic [31:0] wdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= bsa_pkg::PADDR_W'(4 * int'(idx));
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (!is_write) begin
      if (idx == bsa_pkg::REG_PROCESS_COUNT && prdata[bsa_pkg::PC_W-1:0] != proc_cfg)
        report_mismatch("process_count read-back", prdata[bsa_pkg::PC_W-1:0], proc_cfg);
      if (idx == bsa_pkg::REG_RESOURCE_COUNT && prdata[bsa_pkg::RC_W-1:0] != res_cfg)
        report_mismatch("resource_count read-back", prdata[bsa_pkg::RC_W-1:0], res_cfg);
    end
  endtask

  task automatic write_setting(input logic [3:0] pc, input logic [2:0] rc);
    // Only written while the block is idle; every transaction answers, so an empty
    // queue of answers means nothing is in flight.
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    @(posedge clk);
    apb_access(bsa_pkg::REG_PROCESS_COUNT, 1'b1, {28'(0), pc});
    proc_cfg = pc;
    apb_access(bsa_pkg::REG_PROCESS_COUNT, 1'b0, '0);
    apb_access(bsa_pkg::REG_RESOURCE_COUNT, 1'b1, {29'(0), rc});
    res_cfg = rc;
    apb_access(bsa_pkg::REG_RESOURCE_COUNT, 1'b0, '0);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic alloc_txn_t dir_row(input bsa_pkg::kind_t k, input int p, input int a,
                                         input int h, input bit typed,
                                         input bsa_pkg::status_t st, input int fin);
    alloc_txn_t t;
    t.kind = k;
    t.proc_idx = 3'(p);
    for (int r = 0; r < NRES; r++) begin
      t.amt[r] = 16'(a);
      t.hold[r] = 16'(h);
    end
    t.typed = typed;
    t.exp_status = st;
    t.exp_fin = 4'(fin);
    return t;
  endfunction

  // Appends one directed row to the stimulus table.
  function automatic void add_row(input bsa_pkg::kind_t k, input int p, input int a,
                                  input int h, input bit typed,
                                  input bsa_pkg::status_t st, input int fin);
    stim_rows.insert(stim_rows.size(), dir_row(k, p, a, h, typed, st, fin));
  endfunction

  // Random content shaped to get past the request checks: loads mostly legal,
  // requests mostly within the process's need, with some full-range noise.
  function automatic alloc_txn_t random_txn(input int unsigned scale);
    alloc_txn_t t;
    int unsigned pick, p, wide;
    pick = $urandom_range(0, 99);
    t.kind = pick < 25 ? bsa_pkg::KIND_LOAD : pick < 35 ? bsa_pkg::KIND_SET :
             pick < 80 ? bsa_pkg::KIND_REQ : bsa_pkg::KIND_CHECK;
    t.proc_idx = 3'($urandom_range(0, 7));
    p = t.proc_idx;
    t.typed = 1'b0;
    t.exp_status = bsa_pkg::ST_OK;
    t.exp_fin = '0;
    wide = ($urandom_range(0, 9) == 0);
    for (int r = 0; r < NRES; r++) begin
      t.hold[r] = 16'($urandom_range(0, 65535));
      t.amt[r] = wide ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, scale));
      if (t.kind == bsa_pkg::KIND_LOAD) begin
        t.hold[r] = 16'($urandom_range(0, t.amt[r]));
        if ($urandom_range(0, 19) == 0 && t.amt[r] != 16'hFFFF)
          t.hold[r] = t.amt[r] + 16'd1;
      end else if (t.kind == bsa_pkg::KIND_SET && !wide) begin
        t.amt[r] = 16'($urandom_range(0, 2 * scale));
      end else if (t.kind == bsa_pkg::KIND_REQ && $urandom_range(0, 4) != 0) begin
        t.amt[r] = 16'($urandom_range(0, need_tab[p][r]));
      end
    end
    return t;
  endfunction

  initial begin
    logic [3:0] pc_list [8] = '{4'd8, 4'd0, 4'd1, 4'd15, 4'd3, 4'd8, 4'd5, 4'd8};
    logic [2:0] rc_list [8] = '{3'd4, 3'd0, 3'd1, 3'd7, 3'd2, 3'd3, 3'd4, 3'd4};
    int unsigned scale, total;

    proc_cfg = bsa_pkg::PC_RESET;
    res_cfg = bsa_pkg::RC_RESET;
    for (int p = 0; p < NPROC; p++)
      for (int r = 0; r < NRES; r++) begin
        held_tab[p][r] = '0;
        need_tab[p][r] = '0;
      end
    for (int r = 0; r < NRES; r++) free_cnt[r] = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, at the reset setting of eight processes and three resources.
    add_row(bsa_pkg::KIND_CHECK, 0, 0, 0, 1, bsa_pkg::ST_OK, 8);       // empty tables are safe
    add_row(bsa_pkg::KIND_LOAD, 0, 5, 6, 1, bsa_pkg::ST_BAD, 0);       // held above maximum
    add_row(bsa_pkg::KIND_LOAD, 7, 16'hFFFF, 0, 1, bsa_pkg::ST_OK, 0); // largest maximum
    add_row(bsa_pkg::KIND_SET, 0, 16'hFFFF, 0, 1, bsa_pkg::ST_OK, 0);  // largest free counts
    add_row(bsa_pkg::KIND_REQ, 7, 16'hFFFF, 0, 0, bsa_pkg::ST_OK, 0);  // takes everything
    add_row(bsa_pkg::KIND_REQ, 7, 1, 0, 1, bsa_pkg::ST_NEED, 0);       // no need left
    add_row(bsa_pkg::KIND_LOAD, 1, 3, 1, 1, bsa_pkg::ST_OK, 0);
    add_row(bsa_pkg::KIND_REQ, 1, 1, 0, 1, bsa_pkg::ST_AVAIL, 0);      // nothing free
    add_row(bsa_pkg::KIND_CHECK, 0, 0, 0, 0, bsa_pkg::ST_OK, 0);
    add_row(bsa_pkg::KIND_LOAD, 7, 0, 0, 1, bsa_pkg::ST_OK, 0);        // releases the holdings
    add_row(bsa_pkg::KIND_SET, 0, 4, 0, 1, bsa_pkg::ST_OK, 0);
    add_row(bsa_pkg::KIND_LOAD, 2, 8, 0, 1, bsa_pkg::ST_OK, 0);
    add_row(bsa_pkg::KIND_REQ, 1, 2, 0, 0, bsa_pkg::ST_OK, 0);         // unsafe, rolled back
    add_row(bsa_pkg::KIND_CHECK, 0, 0, 0, 0, bsa_pkg::ST_OK, 0);
    add_row(bsa_pkg::KIND_REQ, 1, 1, 0, 0, bsa_pkg::ST_OK, 0);         // still unsafe
    add_row(bsa_pkg::KIND_LOAD, 2, 0, 0, 1, bsa_pkg::ST_OK, 0);
    add_row(bsa_pkg::KIND_CHECK, 0, 0, 0, 1, bsa_pkg::ST_OK, 8);
    foreach (stim_rows[i]) send_txn(stim_rows[i], 1'b1);

    // Random part: one phase per setting, the pause before each write drains the block.
    total = 0;
    foreach (pc_list[ph]) begin
      write_setting(pc_list[ph], rc_list[ph]);
      if (ph == 2) begin
        write_setting(4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)));
      end
      scale = (ph % 3 == 0) ? 15 : (ph % 3 == 1) ? 255 : 4095;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // No idling in the last stretch of the run.
        send_txn(random_txn(scale), total < 8 * ITEMS_PER_PHASE - 300);
        total++;
      end
    end
    start <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("bankers_safety_allocator verification clean");
    end else begin
      $display("bankers_safety_allocator verification failed");
    end
    $finish;
  end

endmodule
